// ===== rtl/csv_embedded_quote_marker_core_assert.svh =====
// Assertion macros used by the quote marker core.
`ifndef CSV_EMBEDDED_QUOTE_MARKER_CORE_ASSERT_SVH
`define CSV_EMBEDDED_QUOTE_MARKER_CORE_ASSERT_SVH

// The condition must never hold at a clock edge outside reset.
`define CSVEQM_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("csveqm: forbidden condition seen");

// Whenever the antecedent holds, the consequent holds in the same cycle.
`define CSVEQM_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csveqm: implication violated");

`endif

// ===== rtl/csveqm_pkg.sv =====
// Types and constants of the CSV embedded quote marker.
package csveqm_pkg;

    localparam int MIN_LINE   = 5;
    localparam int HOLD_DEPTH = MIN_LINE - 1;
    localparam int HOLD_IDX_W = (HOLD_DEPTH > 1) ? $clog2(HOLD_DEPTH) : 1;
    localparam int CNT_W      = $clog2(MIN_LINE + 1);
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_SUB_COMMA = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_SUB_QUOTE = CFG_IDX_W'(1);

    localparam logic [7:0] CH_COMMA        = 8'h2C;
    localparam logic [7:0] CH_QUOTE        = 8'h22;
    localparam logic [7:0] SUB_COMMA_RESET = 8'h01;
    localparam logic [7:0] SUB_QUOTE_RESET = 8'h02;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_beat_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } out_beat_t;

    // One queued work item for the back end.
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       first;
        logic       raw;
    } op_t;

endpackage

// ===== rtl/csv_embedded_quote_marker_core.sv =====
// A byte of a long line passes through the queue and then the output register to out_data.
// The first four bytes of a line wait for the fifth byte or the last flag; that beat then
// pauses input while the held bytes and the beat itself enter the queue.
// Throughput is otherwise one byte per cycle while out_ready is high, set by the
// single-beat back end; a quote inside a field is held back while its next byte is awaited.
// Reset (rst_n, async low) empties the queue and clears line and quote state.
module csv_embedded_quote_marker_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  csveqm_pkg::in_beat_t                   in_data,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output csveqm_pkg::out_beat_t                  out_data,
    input  logic                                   cfg_we,
    input  logic [csveqm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [csveqm_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import csveqm_pkg::*;

`include "csv_embedded_quote_marker_core_assert.svh"

    logic [7:0] sub_comma_reg;
    logic [7:0] sub_quote_reg;
    logic       q_push;
    op_t        q_op;
    logic       q_full;
    logic       q_pop;
    logic       q_valid;
    op_t        q_head;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sub_comma_reg <= SUB_COMMA_RESET;
            sub_quote_reg <= SUB_QUOTE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SUB_COMMA: sub_comma_reg <= cfg_data;
                REG_SUB_QUOTE: sub_quote_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    csveqm_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_op     (q_op)
    );

    csveqm_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_op    (q_op),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_op    (q_head)
    );

    csveqm_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head_op    (q_head),
        .pop        (q_pop),
        .sub_comma  (sub_comma_reg),
        .sub_quote  (sub_quote_reg),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_data   (out_data)
    );

    // The front end must never push into a full queue, or a beat would be lost.
    `CSVEQM_NEVER(a_no_push_when_full, clk, rst_n, q_push && q_full)
    // The back end only consumes an item that the queue holds.
    `CSVEQM_IMPLY(a_pop_has_head, clk, rst_n, q_pop, q_valid)

endmodule

// ===== rtl/csveqm_front.sv =====
// Front end: counts line length, holds the opening bytes and queues work items.
module csveqm_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  csveqm_pkg::in_beat_t in_data,
    input  logic               q_full,
    output logic               q_push,
    output csveqm_pkg::op_t    q_op
);
    import csveqm_pkg::*;

    logic [7:0]       held_reg [HOLD_DEPTH];
    logic [CNT_W-1:0] count_reg, count_next;
    logic             replay_reg, replay_next;
    logic             rep_raw_reg, rep_raw_next;
    logic [CNT_W-1:0] rep_idx_reg, rep_idx_next;
    logic [CNT_W-1:0] rep_len_reg, rep_len_next;
    logic [7:0]       trig_data_reg, trig_data_next;
    logic             trig_last_reg, trig_last_next;
    logic             hold_we;
    logic             in_fire;

    assign in_ready = !replay_reg && !q_full;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        count_next     = count_reg;
        replay_next    = replay_reg;
        rep_raw_next   = rep_raw_reg;
        rep_idx_next   = rep_idx_reg;
        rep_len_next   = rep_len_reg;
        trig_data_next = trig_data_reg;
        trig_last_next = trig_last_reg;
        hold_we        = 1'b0;
        q_push         = 1'b0;
        q_op           = '0;

        if (replay_reg)
        begin
            if (!q_full)
            begin
                q_push    = 1'b1;
                q_op.raw  = rep_raw_reg;
                if (rep_idx_reg < rep_len_reg)
                begin
                    q_op.data    = held_reg[rep_idx_reg[HOLD_IDX_W-1:0]];
                    q_op.first   = (rep_idx_reg == '0) && !rep_raw_reg;
                    rep_idx_next = rep_idx_reg + CNT_W'(1);
                end
                else
                begin
                    q_op.data   = trig_data_reg;
                    q_op.last   = trig_last_reg;
                    replay_next = 1'b0;
                end
            end
        end
        else if (in_fire)
        begin
            if (count_reg < CNT_W'(HOLD_DEPTH))
            begin
                if (in_data.in_last)
                begin
                    count_next = '0;
                    if (count_reg == '0)
                    begin
                        // A one-byte line goes straight through.
                        q_push    = 1'b1;
                        q_op.data = in_data.in_byte;
                        q_op.last = 1'b1;
                        q_op.raw  = 1'b1;
                    end
                    else
                    begin
                        replay_next    = 1'b1;
                        rep_raw_next   = 1'b1;
                        rep_idx_next   = '0;
                        rep_len_next   = count_reg;
                        trig_data_next = in_data.in_byte;
                        trig_last_next = 1'b1;
                    end
                end
                else
                begin
                    hold_we    = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            else if (count_reg == CNT_W'(HOLD_DEPTH))
            begin
                // The line is long enough: replay the held bytes for marking.
                replay_next    = 1'b1;
                rep_raw_next   = 1'b0;
                rep_idx_next   = '0;
                rep_len_next   = CNT_W'(HOLD_DEPTH);
                trig_data_next = in_data.in_byte;
                trig_last_next = in_data.in_last;
                count_next     = in_data.in_last ? '0 : CNT_W'(MIN_LINE);
            end
            else
            begin
                q_push    = 1'b1;
                q_op.data = in_data.in_byte;
                q_op.last = in_data.in_last;
                if (in_data.in_last)
                begin
                    count_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (hold_we)
        begin
            held_reg[count_reg[HOLD_IDX_W-1:0]] <= in_data.in_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            replay_reg    <= 1'b0;
            rep_raw_reg   <= 1'b0;
            rep_idx_reg   <= '0;
            rep_len_reg   <= '0;
            trig_data_reg <= '0;
            trig_last_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            replay_reg    <= replay_next;
            rep_raw_reg   <= rep_raw_next;
            rep_idx_reg   <= rep_idx_next;
            rep_len_reg   <= rep_len_next;
            trig_data_reg <= trig_data_next;
            trig_last_reg <= trig_last_next;
        end
    end

endmodule

// ===== rtl/csveqm_fifo.sv =====
// Short queue of work items between the front and back ends.
module csveqm_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  csveqm_pkg::op_t push_op,
    output logic            full,
    input  logic            pop,
    output logic            head_valid,
    output csveqm_pkg::op_t head_op
);
    import csveqm_pkg::*;

    op_t                   slot_reg [FIFO_DEPTH];
    logic [FIFO_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_PTR_W:0]   cnt_reg, cnt_next;
    logic                  do_push;
    logic                  do_pop;

    assign full       = (cnt_reg == (FIFO_PTR_W + 1)'(FIFO_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_op    = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + FIFO_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + FIFO_PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + (FIFO_PTR_W + 1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - (FIFO_PTR_W + 1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

// ===== rtl/csveqm_back.sv =====
// Back end: tracks the quote state and replaces embedded commas and quotes.
module csveqm_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  csveqm_pkg::op_t       head_op,
    output logic                  pop,
    input  logic [7:0]            sub_comma,
    input  logic [7:0]            sub_quote,
    output logic                  out_valid,
    input  logic                  out_ready,
    output csveqm_pkg::out_beat_t out_data
);
    import csveqm_pkg::*;

    logic       out_valid_reg, out_valid_next;
    out_beat_t  out_data_reg, out_data_next;
    logic       field_open_reg, field_open_next;
    logic       pend_reg, pend_next;
    logic [7:0] prev_reg, prev_next;
    logic       fire;
    logic       emit;
    logic [7:0] emit_byte;
    logic       emit_last;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign fire      = head_valid && (!out_valid_reg || out_ready);

    always_comb
    begin
        field_open_next = field_open_reg;
        pend_next       = pend_reg;
        prev_next       = prev_reg;
        emit            = 1'b1;
        emit_byte       = head_op.data;
        emit_last       = 1'b0;
        pop             = 1'b0;

        if (fire)
        begin
            if (head_op.raw)
            begin
                pop       = 1'b1;
                emit_last = head_op.last;
            end
            else if (head_op.first)
            begin
                pop             = 1'b1;
                emit_last       = head_op.last;
                field_open_next = (head_op.data == CH_QUOTE);
                prev_next       = head_op.data;
            end
            else if (pend_reg)
            begin
                // Flush the held quote; the current byte is handled next beat.
                pend_next = 1'b0;
                if (head_op.data == CH_COMMA)
                begin
                    emit_byte       = CH_QUOTE;
                    field_open_next = 1'b0;
                    prev_next       = CH_QUOTE;
                end
                else
                begin
                    emit_byte = sub_quote;
                    prev_next = sub_quote;
                end
            end
            else if (field_open_reg)
            begin
                pop       = 1'b1;
                emit_last = head_op.last;
                if (head_op.data == CH_COMMA)
                begin
                    emit_byte = sub_comma;
                    prev_next = sub_comma;
                end
                else if (head_op.data == CH_QUOTE)
                begin
                    if (!head_op.last)
                    begin
                        // Its fate depends on the next byte.
                        emit      = 1'b0;
                        pend_next = 1'b1;
                    end
                    else
                    begin
                        field_open_next = 1'b0;
                        prev_next       = head_op.data;
                    end
                end
                else
                begin
                    prev_next = head_op.data;
                end
            end
            else
            begin
                pop       = 1'b1;
                emit_last = head_op.last;
                if (head_op.data == CH_QUOTE)
                begin
                    if (prev_reg == CH_COMMA)
                    begin
                        field_open_next = 1'b1;
                    end
                    else
                    begin
                        emit_byte = sub_quote;
                    end
                end
                prev_next = emit_byte;
            end

            if (pop && head_op.last)
            begin
                field_open_next = 1'b0;
                pend_next       = 1'b0;
                prev_next       = '0;
            end
        end
        else
        begin
            emit = 1'b0;
        end

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (fire && emit)
        begin
            out_valid_next         = 1'b1;
            out_data_next.out_byte = emit_byte;
            out_data_next.out_last = emit_last;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            field_open_reg <= 1'b0;
            pend_reg       <= 1'b0;
            prev_reg       <= '0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            field_open_reg <= field_open_next;
            pend_reg       <= pend_next;
            prev_reg       <= prev_next;
        end
    end

endmodule

// ===== test/csv_embedded_quote_marker_core_test.sv =====
// Self-checking testbench for the CSV embedded quote marker core.
`timescale 1ns / 1ps

module csv_embedded_quote_marker_core_test;
    import csveqm_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int RANDOM_ITEMS = 375;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);

    typedef enum int {RX_ALWAYS, RX_RANDOM, RX_PERIODIC} rx_mode_t;
    typedef logic [7:0] csv_line_t [$];

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_beat_t              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_beat_t             out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Mirror of the block state, updated at every accepted input beat.
    logic [7:0] ovr_comma = SUB_COMMA_RESET;
    logic [7:0] ovr_quote = SUB_QUOTE_RESET;
    logic       field_open = 1'b0;
    logic [7:0] held_bytes [HOLD_DEPTH];
    int         line_cnt = 0;
    logic [7:0] pend_byte = '0;
    logic       pend_valid = 1'b0;
    logic [7:0] prev_byte = '0;

    out_beat_t  marked_q [$];
    int         mismatch_count = 0;
    int         items_sent = 0;
    int         burst_left = 0;
    int         gap_max = 0;
    rx_mode_t   rx_mode = RX_ALWAYS;
    logic       hold_off_req = 1'b0;
    int         quiet_cycles = 0;

    csv_embedded_quote_marker_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void expect_byte(logic [7:0] b, logic l);
        out_beat_t e;
        e.out_byte = b;
        e.out_last = l;
        marked_q.push_back(e);
    endfunction

    // One byte of a line that is known to be long enough for marking.
    function automatic void mark_long_byte(logic [7:0] b, bit first, logic l);
        logic [7:0] v;
        if (first)
        begin
            field_open = (b == CH_QUOTE);
            prev_byte = b;
            expect_byte(b, l);
            return;
        end
        if (pend_valid)
        begin
            pend_valid = 1'b0;
            if (b == CH_COMMA)
            begin
                // A quote followed by a comma closes the field; both pass as they are.
                expect_byte(pend_byte, 1'b0);
                expect_byte(b, l);
                prev_byte = b;
                field_open = 1'b0;
                return;
            end
            expect_byte(ovr_quote, 1'b0);
            prev_byte = ovr_quote;
        end
        v = b;
        if (field_open)
        begin
            if (b == CH_COMMA)
                v = ovr_comma;
            else if (b == CH_QUOTE)
            begin
                if (!l)
                begin
                    pend_byte = b;
                    pend_valid = 1'b1;
                    return;
                end
                field_open = 1'b0;
            end
        end
        else if (b == CH_QUOTE)
        begin
            // The previous byte is compared as sent, overrides included.
            if (prev_byte == CH_COMMA)
                field_open = 1'b1;
            else
                v = ovr_quote;
        end
        expect_byte(v, l);
        prev_byte = v;
    endfunction

    function automatic void mark_beat(in_beat_t d);
        if (line_cnt < HOLD_DEPTH)
        begin
            if (d.in_last)
            begin
                for (int k = 0; k < line_cnt; k++)
                    expect_byte(held_bytes[k], 1'b0);
                expect_byte(d.in_byte, 1'b1);
            end
            else
            begin
                held_bytes[line_cnt] = d.in_byte;
                line_cnt++;
            end
        end
        else if (line_cnt == HOLD_DEPTH)
        begin
            for (int k = 0; k < HOLD_DEPTH; k++)
                mark_long_byte(held_bytes[k], k == 0, 1'b0);
            mark_long_byte(d.in_byte, 1'b0, d.in_last);
            line_cnt = MIN_LINE;
        end
        else
            mark_long_byte(d.in_byte, 1'b0, d.in_last);
        if (d.in_last)
        begin
            line_cnt = 0;
            field_open = 1'b0;
            pend_valid = 1'b0;
            pend_byte = '0;
            prev_byte = '0;
        end
    endfunction

    task automatic send_beat(logic [7:0] b, logic l);
        in_beat_t d;
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        d.in_byte = b;
        d.in_last = l;
        in_data <= d;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        mark_beat(d);
        items_sent++;
    endtask

    task automatic send_csv_line(csv_line_t csv_line);
        foreach (csv_line[k])
            send_beat(csv_line[k], k == csv_line.size() - 1);
    endtask

    function automatic logic [7:0] text_byte();
        if ($urandom_range(0, 3) == 0)
            return 8'($urandom_range(0, 255));
        return 8'($urandom_range(8'h41, 8'h7A));
    endfunction

    // Mostly well-formed lines of plain and quoted fields, the rest noise.
    function automatic csv_line_t random_csv_line();
        csv_line_t csv_line;
        int nfields;
        int len;
        int pick;
        if ($urandom_range(0, 9) < 7)
        begin
            nfields = $urandom_range(1, 5);
            for (int f = 0; f < nfields; f++)
            begin
                if (f > 0)
                    csv_line.push_back(CH_COMMA);
                len = $urandom_range(0, 6);
                if ($urandom_range(0, 1) == 1)
                begin
                    csv_line.push_back(CH_QUOTE);
                    for (int k = 0; k < len; k++)
                    begin
                        pick = $urandom_range(0, 9);
                        if (pick < 2)
                            csv_line.push_back(CH_COMMA);
                        else if (pick == 2)
                        begin
                            csv_line.push_back(CH_QUOTE);
                            csv_line.push_back(CH_QUOTE);
                        end
                        else if (pick == 3)
                            csv_line.push_back(CH_QUOTE);
                        else
                            csv_line.push_back(text_byte());
                    end
                    csv_line.push_back(CH_QUOTE);
                end
                else
                    for (int k = 0; k < len; k++)
                        csv_line.push_back(($urandom_range(0, 9) == 0) ? CH_QUOTE : text_byte());
            end
        end
        else
        begin
            len = $urandom_range(1, 12);
            for (int k = 0; k < len; k++)
            begin
                pick = $urandom_range(0, 9);
                if (pick < 3)
                    csv_line.push_back(CH_QUOTE);
                else if (pick < 6)
                    csv_line.push_back(CH_COMMA);
                else
                    csv_line.push_back(8'($urandom_range(0, 255)));
            end
        end
        if (csv_line.size() == 0)
            csv_line.push_back(text_byte());
        return csv_line;
    endfunction

    // Stops offering beats and waits until every marked byte has come back.
    task automatic wait_drain();
        in_valid <= 1'b0;
        while (marked_q.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Writes all four register slots on consecutive edges; the spare ones are ignored.
    task automatic program_overrides(logic [7:0] comma_val, logic [7:0] quote_val);
        logic [CFG_IDX_W-1:0] idx [4];
        logic [7:0] val [4];
        idx = '{REG_SUB_COMMA, REG_SUB_QUOTE, REG_SPARE_A, REG_SPARE_B};
        val = '{comma_val, quote_val, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255))};
        for (int k = 0; k < 4; k++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= idx[k];
            cfg_data <= val[k];
            @(posedge clk);
            if (idx[k] == REG_SUB_COMMA)
                ovr_comma = val[k];
            else if (idx[k] == REG_SUB_QUOTE)
                ovr_quote = val[k];
        end
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic test_directed();
        csv_line_t csv_line;
        gap_max = 3;
        rx_mode = RX_RANDOM;
        // A zero byte is ordinary data; here it is also a one-byte line.
        csv_line = '{8'h00};
        send_csv_line(csv_line);
        // Short line with quotes and commas passes unchanged.
        csv_line = '{CH_QUOTE, CH_COMMA, CH_QUOTE, 8'hFF};
        send_csv_line(csv_line);
        // Shortest marked line; the quote that ends the line also ends the field.
        csv_line = '{CH_QUOTE, 8'h61, CH_COMMA, 8'h62, CH_QUOTE};
        send_csv_line(csv_line);
        csv_line = '{8'h61, CH_QUOTE, CH_COMMA, CH_QUOTE, 8'h78, CH_QUOTE,
                     CH_QUOTE, 8'h79, CH_QUOTE, CH_COMMA, 8'h00, 8'hFF};
        send_csv_line(csv_line);
        csv_line = '{CH_QUOTE, CH_QUOTE};
        send_csv_line(csv_line);
        wait_drain();
    endtask

    task automatic test_config_sweep();
        csv_line_t csv_line;
        logic [7:0] comma_set [5];
        logic [7:0] quote_set [5];
        comma_set = '{8'h00, 8'hFF, CH_COMMA, CH_QUOTE, 8'($urandom_range(0, 255))};
        quote_set = '{8'hFF, 8'h00, CH_COMMA, CH_COMMA, 8'($urandom_range(0, 255))};
        for (int s = 0; s < 5; s++)
        begin
            program_overrides(comma_set[s], quote_set[s]);
            gap_max = s;
            rx_mode = rx_mode_t'(s % 3);
            // An overridden quote that equals a comma lets the next quote open a field.
            csv_line = '{8'h61, CH_QUOTE, CH_QUOTE, 8'h62, CH_COMMA, CH_QUOTE, 8'h63,
                         CH_COMMA, 8'h64, CH_QUOTE, 8'h65};
            send_csv_line(csv_line);
            repeat (3) send_csv_line(random_csv_line());
            wait_drain();
        end
    endtask

    task automatic test_random_lines();
        while (items_sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 5) == 0)
            begin
                gap_max = 0;
                rx_mode = RX_ALWAYS;
            end
            else
            begin
                gap_max = $urandom_range(0, 12);
                rx_mode = rx_mode_t'($urandom_range(0, 2));
            end
            send_csv_line(random_csv_line());
        end
        wait_drain();
    endtask

    // The receiver holds off long enough for the block to fill and stall its input.
    task automatic test_backpressure();
        csv_line_t csv_line;
        gap_max = 0;
        rx_mode = RX_ALWAYS;
        hold_off_req = 1'b1;
        for (int k = 0; k < 29; k++)
            csv_line.push_back((k % 4 == 1) ? CH_QUOTE : ((k % 4 == 3) ? CH_COMMA : text_byte()));
        send_csv_line(csv_line);
        wait_drain();
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config_sweep();
        test_random_lines();
        test_backpressure();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && marked_q.size() == 0)
            $display("csv_embedded_quote_marker_core: match");
        else
            $display("csv_embedded_quote_marker_core: mismatch");
        $finish;
    end

    // Receiver: a long hold-off on request, otherwise the selected stall pattern.
    initial
    begin
        int rx_tick;
        rx_tick = 0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            rx_tick++;
            case (rx_mode)
                RX_ALWAYS:   out_ready <= 1'b1;
                RX_RANDOM:   out_ready <= ($urandom_range(0, 99) < 65);
                RX_PERIODIC: out_ready <= (rx_tick % 7) > 2;
                default:     out_ready <= 1'b1;
            endcase
        end
    end

    always @(posedge clk)
    begin
        out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (marked_q.size() == 0)
            begin
                if (mismatch_count < 10)
                    $display("unexpected output beat: byte %02h last %0b",
                             out_data.out_byte, out_data.out_last);
                mismatch_count++;
            end
            else
            begin
                want = marked_q.pop_front();
                if (out_data.out_byte !== want.out_byte || out_data.out_last !== want.out_last)
                begin
                    if (mismatch_count < 10)
                        $display({"output beat differs: expected byte %02h last %0b, ",
                                  "got byte %02h last %0b"},
                                 want.out_byte, want.out_last, out_data.out_byte,
                                 out_data.out_last);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("csv_embedded_quote_marker_core: mismatch");
            $finish;
        end
    end

endmodule
